@@ hdl/bfq_pkg.sv @@
package bfq_pkg;

    // default geometry
    localparam int BFQ_DEPTH       = 64;
    localparam int BFQ_HANDLE_BITS = 32;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int HANDLE_W = 32;
    localparam int EPOCH_W  = 32;
    localparam int CNT_W    = 32;
    localparam int OCC_W    = 7;
    localparam int CAP_W    = 7;
    localparam int CFG_IDX_W = 1;

    // input and output bus widths, rounded up to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 176;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_POLICY    = 1'd1;

    // full policy codes
    localparam logic POLICY_DROP_OLDEST  = 1'b0;
    localparam logic POLICY_REJECT_NEWEST = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_GEN   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_STALE   = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_EMPTY   = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // one result item
    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] popped;
        logic [OCC_W-1:0]    occupancy;
        logic [EPOCH_W-1:0]  epoch;
        logic [CNT_W-1:0]    stale;
        logic [CNT_W-1:0]    rejects;
        logic [CNT_W-1:0]    drops;
        logic [OCC_W-1:0]    peak;
    } t_result;

    // saturating counter step
    function automatic logic [CNT_W-1:0] f_sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

@@ hdl/bfq_store.sv @@
module bfq_store
    import bfq_pkg::*;
#(
    parameter int DEPTH       = BFQ_DEPTH,
    parameter int HANDLE_BITS = BFQ_HANDLE_BITS,
    localparam int PW         = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [PW-1:0]          i_waddr,
    input  logic [HANDLE_BITS-1:0] i_wdata,
    input  logic                   i_re,
    input  logic [PW-1:0]          i_raddr,
    output logic [HANDLE_BITS-1:0] o_rdata
);

    logic [HANDLE_BITS-1:0] r_mem [DEPTH];
    logic [HANDLE_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bounded_frame_queue_with_epoch.sv @@
// Bounded frame queue with epoch tag. Frame handles live in a circular
// single-port-write, registered-read store of DEPTH entries; pointers, count,
// epoch, three saturating counters and the peak occupancy sit in registers.
// The usable capacity is the smaller of the queue_capacity register and DEPTH.
// Each request (s_axis_tuser = op) gives exactly one result; for push, set
// generation and clear the result is registered on acceptance, while a pop
// that finds data passes through the read state, in which the head entry
// comes out of the registered store into the result stage. A result
// stage sits in front of the output register, so a result waiting on the
// master side lets one more request in and holds off requests only once that
// stage is full as well. The store is not cleared after reset, so the block is
// ready as soon as reset is released. Configuration must be written only while
// no request is in progress; the block itself does not enforce this.
module bounded_frame_queue_with_epoch
    import bfq_pkg::*;
#(
    parameter int DEPTH       = BFQ_DEPTH,
    parameter int HANDLE_BITS = BFQ_HANDLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CAP_W-1:0]      i_cfg_data,
    // request channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // frame_handle[31:0], frame_ok[32],
                                                  // item_generation[64:33], zero fill
    input  logic [OP_W-1:0]       s_axis_tuser,   // op[1:0]
    // result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // popped_handle[31:0], occupancy[38:32],
                                                  // current_epoch[70:39],
                                                  // stale_rejects[102:71],
                                                  // full_rejects[134:103],
                                                  // oldest_drops[166:135],
                                                  // peak_occupancy[173:167], zero fill
    output logic [STATUS_W-1:0]   m_axis_tuser    // status[2:0]
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    // wrap a store pointer
    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // configuration registers
    logic [CAP_W-1:0] r_cap;
    logic             r_policy;

    // queue state
    logic [PW-1:0]      r_head, n_head;
    logic [PW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_peak, n_peak;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [CNT_W-1:0]   r_stale, n_stale;
    logic [CNT_W-1:0]   r_rejects, n_rejects;
    logic [CNT_W-1:0]   r_drops, n_drops;
    t_status            n_status;

    // control
    t_state  r_state, n_state;
    logic    r_res_valid;
    logic    r_out_valid;
    t_result r_res;
    t_result r_out;

    logic                   w_accept;
    logic                   w_res_done;
    logic                   w_out_load;
    logic                   w_ready;
    logic                   w_we;
    logic                   w_re;
    logic                   w_pop_hit;
    logic                   w_cap_zero;
    logic                   w_full;
    logic [CMPW-1:0]        w_cap_eff;
    t_op                    w_op;
    logic [HANDLE_W-1:0]    w_handle;
    logic                   w_ok;
    logic [EPOCH_W-1:0]     w_gen;
    logic [HANDLE_BITS-1:0] w_rdata;

    // request fields
    assign w_op     = t_op'(s_axis_tuser);
    assign w_handle = s_axis_tdata[31:0];
    assign w_ok     = s_axis_tdata[32];
    assign w_gen    = s_axis_tdata[64:33];

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_W'(64);
            r_policy <= POLICY_DROP_OLDEST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUEUE_CAPACITY: r_cap    <= i_cfg_data;
                CFG_FULL_POLICY:    r_policy <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // usable capacity and full test
    assign w_cap_eff  = (CMPW'(r_cap) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(r_cap);
    assign w_cap_zero = (r_cap == '0);
    assign w_full     = (CMPW'(r_count) >= w_cap_eff);

    // operation decode and next queue state
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_epoch   = r_epoch;
        n_stale   = r_stale;
        n_rejects = r_rejects;
        n_drops   = r_drops;
        n_peak    = r_peak;
        n_status  = STAT_OK;
        w_we      = 1'b0;
        w_pop_hit = 1'b0;
        if (w_accept) begin
            case (w_op)
                OP_PUSH: begin
                    if (w_cap_zero || !w_ok) begin
                        n_status = STAT_INVALID;
                    end else if (w_gen != r_epoch) begin
                        n_stale  = f_sat_inc(r_stale);
                        n_status = STAT_STALE;
                    end else if (w_full && (r_policy == POLICY_REJECT_NEWEST)) begin
                        n_rejects = f_sat_inc(r_rejects);
                        n_status  = STAT_FULL;
                    end else begin
                        // drop oldest keeps the count where it is
                        if (w_full) begin
                            n_head  = f_wrap(r_head);
                            n_drops = f_sat_inc(r_drops);
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                        w_we   = 1'b1;
                        n_tail = f_wrap(r_tail);
                    end
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        w_pop_hit = 1'b1;
                        n_head    = f_wrap(r_head);
                        n_count   = r_count - 1'b1;
                    end
                end
                OP_GEN: begin
                    if (w_cap_zero) begin
                        n_status = STAT_INVALID;
                    end else if (w_gen != r_epoch) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_count = '0;
                        n_epoch = w_gen;
                    end
                end
                OP_CLEAR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                default: ;
            endcase
            if (n_count > r_peak) begin
                n_peak = n_count;
            end
        end
    end

    // handle store, written on push and read at the head on pop
    bfq_store #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (HANDLE_BITS'(w_handle)),
        .i_re    (w_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // result stage hand-off to the output register
    assign w_res_done = r_res_valid && (r_state == S_IDLE);
    assign w_out_load = w_res_done && (!r_out_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_pop_hit) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready = 1'b0;
        case (r_state)
            S_IDLE:  w_ready = !r_res_valid || w_out_load;
            S_READ:  w_ready = 1'b0;
            default: w_ready = 1'b0;
        endcase
    end

    assign s_axis_tready = w_ready;
    assign w_re          = w_pop_hit;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_epoch     <= '0;
            r_stale     <= '0;
            r_rejects   <= '0;
            r_drops     <= '0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_peak    <= n_peak;
            r_epoch   <= n_epoch;
            r_stale   <= n_stale;
            r_rejects <= n_rejects;
            r_drops   <= n_drops;
            if (w_accept) begin
                r_res_valid <= 1'b1;
            end else if (w_out_load) begin
                r_res_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; on a pop the popped handle is taken from the store output in the read state
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res.status    <= n_status;
            r_res.popped    <= '0;
            r_res.occupancy <= OCC_W'(n_count);
            r_res.epoch     <= n_epoch;
            r_res.stale     <= n_stale;
            r_res.rejects   <= n_rejects;
            r_res.drops     <= n_drops;
            r_res.peak      <= OCC_W'(n_peak);
        end else if (r_state == S_READ) begin
            r_res.popped <= HANDLE_W'(w_rdata);
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    // result bus packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {2'b00, r_out.peak, r_out.drops, r_out.rejects, r_out.stale,
                            r_out.epoch, r_out.occupancy, r_out.popped};

    // count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(DEPTH))
        else $error("queue count beyond depth");

    // an empty or completely full ring has head and tail together
    a_ring_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || CMPW'(r_count) == CMPW'(DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail disagree with count");

    // peak occupancy tracks the count
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_count)
        else $error("peak occupancy below count");

    // a pop that finds data goes through the read state and holds off requests
    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_hit |=> (r_state == S_READ) && !s_axis_tready)
        else $error("pop did not wait for store read");

endmodule
